### design/ppm_pkg.sv
`timescale 1ns / 1ps

package ppm_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CHANNEL_COUNT = 3'd0,
		CFG_PULSE_WIDTH   = 3'd1,
		CFG_FRAME_PERIOD  = 3'd2,
		CFG_ACTIVE_HIGH   = 3'd3
	} cfg_index_t;

	localparam logic [4:0]  MIN_CHANNELS    = 5'd4;
	localparam logic [15:0] PULSE_MIN_US    = 16'd100;
	localparam logic [15:0] PULSE_MAX_US    = 16'd1000;
	localparam logic [15:0] FRAME_MIN_US    = 16'd10000;
	localparam logic [15:0] FRAME_MAX_US    = 16'd40000;
	localparam logic [15:0] WIDTH_MIN_US    = 16'd800;
	localparam logic [15:0] WIDTH_MAX_US    = 16'd2200;
	localparam logic [14:0] SYNC_FALLBACK   = 15'd3000;
	localparam logic [17:0] SYNC_SATURATE   = 18'd32767;

	localparam logic [4:0]  RST_CHANNELS    = 5'd8;
	localparam logic [15:0] RST_PULSE_US    = 16'd300;
	localparam logic [15:0] RST_FRAME_US    = 16'd22500;

endpackage

### design/ppm_frame_symbol_generator.sv
`timescale 1ns / 1ps

// PPM frame symbol generator. Each input transaction carries one RC channel
// width in microseconds; the block clamps it to 800..2200 us (and lifts it
// above the separator pulse if needed) and returns one pulse/gap symbol: the
// active level for the pulse width, then the idle level for the rest of the
// slot. Once the configured number of channels has been sent, a second
// symbol follows carrying the sync gap (frame period minus time used minus
// pulse, 3000 us if that is not positive, capped at 32767 us) with
// sync_symbol set; last_of_run flags the final symbol of each input
// transaction. Throughput: one input transaction per cycle when out_stall is
// low; the transaction that closes a frame yields two symbols, and the single
// output register issues one symbol per cycle when not stalled. A symbol
// passes the input register, then the result register. While a symbol waits
// at the output, the input register can take one more transaction and then
// stalls. Config registers are written through cfg_* (always ready) and must
// only be changed while the block is idle; they are clamped at use, never
// rejected.
module ppm_frame_symbol_generator #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  ppm_pkg::cfg_index_t  cfg_index,
	input  logic [15:0]          cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          channel_width_us,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 first_level,
	output logic [9:0]           first_duration_us,
	output logic                 second_level,
	output logic [14:0]          second_duration_us,
	output logic                 sync_symbol,
	output logic                 last_of_run
);

	import ppm_pkg::*;

	// slot counter never passes MAX_CHANNELS
	localparam int         CNT_W   = $clog2(MAX_CHANNELS + 1);
	localparam logic [4:0] MAX_CH5 = 5'(MAX_CHANNELS);

	// config registers
	logic [4:0]  channel_count_q;
	logic [15:0] pulse_width_q;
	logic [15:0] frame_period_q;
	logic        active_high_q;

	// frame state
	logic [CNT_W-1:0] slot_q;
	logic [15:0]      used_q;

	// input register
	logic        valid_s1;
	logic [15:0] width_s1;

	// result register and the held sync gap
	logic        valid_s2;
	logic [9:0]  pulse_s2;
	logic        act_s2;
	logic [14:0] gap_s2;
	logic        sync_s2;
	logic        last_s2;
	logic        pend_q;
	logic [14:0] sync_gap_q;

	logic             out_take;
	logic             move_s1;
	logic             load_s1;
	logic [CNT_W-1:0] count_c;
	logic [9:0]       pulse_c;
	logic [15:0]      frame_c;
	logic [15:0]      width_c;
	logic [15:0]      used_c;
	logic [CNT_W-1:0] slot_c;
	logic             end_c;
	logic [16:0]      need_c;
	logic [17:0]      diff_c;
	logic [14:0]      sync_gap_c;
	logic [14:0]      gap_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RST_CHANNELS;
			pulse_width_q   <= RST_PULSE_US;
			frame_period_q  <= RST_FRAME_US;
			active_high_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[4:0];
				CFG_PULSE_WIDTH:   pulse_width_q   <= cfg_data;
				CFG_FRAME_PERIOD:  frame_period_q  <= cfg_data;
				CFG_ACTIVE_HIGH:   active_high_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: the result register frees up on a take unless the sync
	// symbol is still to follow
	assign out_take = valid_s2 && !out_stall;
	assign move_s1  = valid_s1 && (!valid_s2 || (out_take && !pend_q));
	assign in_stall = valid_s1 && !move_s1;
	assign load_s1  = in_valid && !in_stall;

	// symbol arithmetic on the item leaving the input register
	always_comb begin
		if (channel_count_q < MIN_CHANNELS) begin
			count_c = CNT_W'(MIN_CHANNELS);
		end else if (channel_count_q > MAX_CH5) begin
			count_c = CNT_W'(MAX_CHANNELS);
		end else begin
			count_c = channel_count_q[CNT_W-1:0];
		end

		if (pulse_width_q < PULSE_MIN_US) begin
			pulse_c = PULSE_MIN_US[9:0];
		end else if (pulse_width_q > PULSE_MAX_US) begin
			pulse_c = PULSE_MAX_US[9:0];
		end else begin
			pulse_c = pulse_width_q[9:0];
		end

		if (frame_period_q < FRAME_MIN_US) begin
			frame_c = FRAME_MIN_US;
		end else if (frame_period_q > FRAME_MAX_US) begin
			frame_c = FRAME_MAX_US;
		end else begin
			frame_c = frame_period_q;
		end

		if (width_s1 < WIDTH_MIN_US) begin
			width_c = WIDTH_MIN_US;
		end else if (width_s1 > WIDTH_MAX_US) begin
			width_c = WIDTH_MAX_US;
		end else begin
			width_c = width_s1;
		end
		// slot must stay longer than the separator pulse
		if (width_c <= {6'd0, pulse_c}) begin
			width_c = {6'd0, pulse_c} + 16'd1;
		end

		gap_c  = 15'(width_c - {6'd0, pulse_c});
		used_c = used_q + width_c;
		slot_c = slot_q + CNT_W'(1);
		end_c  = slot_c >= count_c;

		need_c = {1'b0, used_c} + {7'd0, pulse_c};
		diff_c = {2'b00, frame_c} - {1'b0, need_c};
		if ({1'b0, frame_c} > need_c) begin
			sync_gap_c = (diff_c > SYNC_SATURATE) ? SYNC_SATURATE[14:0] : diff_c[14:0];
		end else begin
			sync_gap_c = SYNC_FALLBACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pend_q   <= 1'b0;
			slot_q   <= '0;
			used_q   <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end

			if (move_s1) begin
				valid_s2 <= 1'b1;
				pend_q   <= end_c;
				slot_q   <= end_c ? '0 : slot_c;
				used_q   <= end_c ? '0 : used_c;
			end else if (out_take) begin
				// either the sync symbol moves up or the register drains
				valid_s2 <= pend_q;
				pend_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			width_s1 <= channel_width_us;
		end
		if (move_s1) begin
			pulse_s2   <= pulse_c;
			act_s2     <= active_high_q;
			gap_s2     <= gap_c;
			sync_s2    <= 1'b0;
			last_s2    <= !end_c;
			sync_gap_q <= sync_gap_c;
		end else if (out_take && pend_q) begin
			gap_s2  <= sync_gap_q;
			sync_s2 <= 1'b1;
			last_s2 <= 1'b1;
		end
	end

	assign out_valid          = valid_s2;
	assign first_level        = act_s2;
	assign first_duration_us  = pulse_s2;
	assign second_level       = !act_s2;
	assign second_duration_us = gap_s2;
	assign sync_symbol        = sync_s2;
	assign last_of_run        = last_s2;

endmodule

### tb/sv/ppm_symbol_checker.sv
`timescale 1ns / 1ps

// Watches the config, input and output channels, predicts the symbols of
// every accepted channel width and compares them with what comes out.
module ppm_symbol_checker #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  ppm_pkg::cfg_index_t cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [15:0]         channel_width_us,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                first_level,
	input  logic [9:0]          first_duration_us,
	input  logic                second_level,
	input  logic [14:0]         second_duration_us,
	input  logic                sync_symbol,
	input  logic                last_of_run,
	output int                  fail_count,
	output int                  pending
);
	import ppm_pkg::*;

	typedef struct packed {
		logic        first_level;
		logic [9:0]  first_dur;
		logic        second_level;
		logic [14:0] second_dur;
		logic        sync;
		logic        last;
	} symbol_t;

	// shadow registers and frame state
	logic [4:0]  chan_count;
	logic [15:0] pulse_reg;
	logic [15:0] frame_reg;
	logic        act_level;
	logic [4:0]  slots_done;
	logic [15:0] used_us;

	symbol_t expected_symbols[$];
	symbol_t got_sym;
	symbol_t want_sym;
	int      mismatches = 0;
	int      outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// one channel width in, one or two symbols queued
	function automatic void encode_channel(input logic [15:0] raw);
		int unsigned count;
		int unsigned pulse;
		int unsigned frame;
		int unsigned width;
		int unsigned gap;
		logic        end_frame;
		symbol_t     sym;
		count = (chan_count < MIN_CHANNELS) ? MIN_CHANNELS :
			(chan_count > MAX_CHANNELS) ? MAX_CHANNELS : chan_count;
		pulse = (pulse_reg < PULSE_MIN_US) ? PULSE_MIN_US :
			(pulse_reg > PULSE_MAX_US) ? PULSE_MAX_US : pulse_reg;
		frame = (frame_reg < FRAME_MIN_US) ? FRAME_MIN_US :
			(frame_reg > FRAME_MAX_US) ? FRAME_MAX_US : frame_reg;
		width = (raw < WIDTH_MIN_US) ? WIDTH_MIN_US :
			(raw > WIDTH_MAX_US) ? WIDTH_MAX_US : raw;
		if (width <= pulse)
			width = pulse + 1;
		used_us    = used_us + width[15:0];
		slots_done = slots_done + 5'd1;
		end_frame  = (slots_done >= count);

		sym.first_level  = act_level;
		sym.first_dur    = pulse[9:0];
		sym.second_level = ~act_level;
		gap              = width - pulse;
		sym.second_dur   = gap[14:0];
		sym.sync         = 1'b0;
		sym.last         = ~end_frame;
		expected_symbols.push_back(sym);

		if (end_frame) begin
			if (frame > used_us + pulse)
				gap = frame - used_us - pulse;
			else
				gap = SYNC_FALLBACK;
			if (gap > SYNC_SATURATE)
				gap = SYNC_SATURATE;
			sym.second_dur = gap[14:0];
			sym.sync       = 1'b1;
			sym.last       = 1'b1;
			expected_symbols.push_back(sym);
			slots_done = '0;
			used_us    = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count  = RST_CHANNELS;
			pulse_reg   = RST_PULSE_US;
			frame_reg   = RST_FRAME_US;
			act_level   = 1'b1;
			slots_done  = '0;
			used_us     = '0;
			expected_symbols.delete();
			outstanding <= 0;
		end else begin
			// results first: nothing can come out in the cycle its input goes in
			if (out_valid && !out_stall) begin
				got_sym = '{first_level, first_duration_us, second_level,
					second_duration_us, sync_symbol, last_of_run};
				if (expected_symbols.size() == 0) begin
					$error("symbol with nothing expected: %p", got_sym);
					mismatches++;
				end else begin
					want_sym = expected_symbols.pop_front();
					check_field("first_level", want_sym.first_level, got_sym.first_level);
					check_field("first_duration_us", want_sym.first_dur,
						got_sym.first_dur);
					check_field("second_level", want_sym.second_level,
						got_sym.second_level);
					check_field("second_duration_us", want_sym.second_dur,
						got_sym.second_dur);
					check_field("sync_symbol", want_sym.sync, got_sym.sync);
					check_field("last_of_run", want_sym.last, got_sym.last);
				end
			end
			if (in_valid && !in_stall)
				encode_channel(channel_width_us);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHANNEL_COUNT: chan_count = cfg_data[4:0];
					CFG_PULSE_WIDTH:   pulse_reg  = cfg_data;
					CFG_FRAME_PERIOD:  frame_reg  = cfg_data;
					CFG_ACTIVE_HIGH:   act_level  = cfg_data[0];
					default: ;
				endcase
			end
			outstanding <= expected_symbols.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Top level: clock, reset, stimulus and the verdict. All prediction and
// comparison lives in ppm_symbol_checker.
module tb;
	import ppm_pkg::*;

	localparam int MAX_CH        = 8;
	localparam int SEGMENTS      = 9;
	localparam int SEG_ITEMS     = 190;
	localparam int HANG_LIMIT    = 3000; // cycles with no transaction at all
	localparam int SETTLE_CYCLES = 20;   // idle cycles after the final drain

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_index_t  cfg_index = CFG_CHANNEL_COUNT;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] channel_width_us = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        first_level;
	logic [9:0]  first_duration_us;
	logic        second_level;
	logic [14:0] second_duration_us;
	logic        sync_symbol;
	logic        last_of_run;

	int fail_count;
	int pending;
	int send_idle_pct = 30; // chance the sender leaves a gap before a transaction
	int stall_pct     = 30; // chance the receiver stalls in a given cycle
	int quiet_cycles  = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ppm_frame_symbol_generator #(.MAX_CHANNELS(MAX_CH)) u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.channel_width_us   (channel_width_us),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.first_level        (first_level),
		.first_duration_us  (first_duration_us),
		.second_level       (second_level),
		.second_duration_us (second_duration_us),
		.sync_symbol        (sync_symbol),
		.last_of_run        (last_of_run)
	);

	ppm_symbol_checker #(.MAX_CHANNELS(MAX_CH)) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.channel_width_us   (channel_width_us),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.first_level        (first_level),
		.first_duration_us  (first_duration_us),
		.second_level       (second_level),
		.second_duration_us (second_duration_us),
		.sync_symbol        (sync_symbol),
		.last_of_run        (last_of_run),
		.fail_count         (fail_count),
		.pending            (pending)
	);

	// Receiver back-pressure, independent of out_valid.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a hung handshake or a lost symbol shows up as a long stretch
	// with no transaction on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// One channel width. Valid stays high across back-to-back transactions;
	// it is only dropped for a random gap or by drain.
	task automatic send_width(input logic [15:0] width);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		channel_width_us <= width;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Hold the sender off until every predicted symbol has been taken.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_settings(input logic [15:0] count, input logic [15:0] pulse,
		input logic [15:0] frame, input logic act);
		write_reg(CFG_CHANNEL_COUNT, count);
		write_reg(CFG_PULSE_WIDTH, pulse);
		write_reg(CFG_FRAME_PERIOD, frame);
		// upper bits are junk, only bit 0 counts
		write_reg(CFG_ACTIVE_HIGH, {15'($urandom), act});
		// an index past the register list must be ignored
		write_reg(cfg_index_t'($urandom_range(4, 7)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] count_v;
		logic [15:0] pulse_v;
		logic [15:0] frame_v;
		logic [15:0] width_v;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// Reset settings (8 channels, 300 us pulse): clamp edges on both sides
		// plus alternating bit patterns; the eighth closes the frame.
		send_width(16'd0);
		send_width(16'hFFFF);
		send_width(16'd799);
		send_width(16'd800);
		send_width(16'd2200);
		send_width(16'd2201);
		send_width(16'h5555);
		send_width(16'hAAAA);
		drain();

		// Pulse above range clamps to 1000, so the 800 us floor is lifted to
		// pulse + 1; frame below range clamps to 10000 and five long slots
		// overrun it, giving the fallback sync gap. Inverted polarity.
		write_settings(16'd5, 16'hFFFF, 16'd0, 1'b0);
		send_width(16'd800);
		send_width(16'd2200);
		send_width(16'd2200);
		send_width(16'd2200);
		send_width(16'd2200);
		drain();

		// Count and pulse below range: 4 channels, 100 us pulse, and a frame above
		// range clamped to 40000 us so the sync gap saturates.
		write_settings(16'd0, 16'd0, 16'hFFFF, 1'b1);
		repeat (4) send_width(16'd0);
		drain();

		// Count above MAX clamps to MAX; then cut the count to 4 in mid-frame
		// with six slots already used, so the next slot ends the frame at once.
		write_settings(16'd16, 16'd300, 16'd40000, 1'b1);
		repeat (6) send_width(16'd2000);
		drain();
		write_reg(CFG_CHANNEL_COUNT, 16'd4);
		cfg_valid <= 1'b0;
		send_width(16'd2000);
		drain();

		// --- random ---
		// Three idling profiles, three segments each: fast sender into a slow
		// receiver, the reverse, then none. Within a profile the settings go
		// to random values, the low extremes and the high extremes.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 3)
				0: begin
					send_idle_pct = 14;
					stall_pct     = 82;
				end
				1: begin
					send_idle_pct = 82;
					stall_pct     = 14;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
			endcase
			case (seg % 3)
				1: begin
					count_v = 16'd0;
					pulse_v = ($urandom_range(1)) ? 16'd0 : 16'd100;
					frame_v = ($urandom_range(1)) ? 16'd0 : 16'd10000;
				end
				2: begin
					count_v = ($urandom_range(1)) ? 16'd31 : 16'(MAX_CH);
					pulse_v = ($urandom_range(1)) ? 16'hFFFF : 16'd1000;
					frame_v = ($urandom_range(1)) ? 16'hFFFF : 16'd40000;
				end
				default: begin
					count_v = 16'($urandom_range(0, 16));
					pulse_v = ($urandom_range(3) == 0) ? 16'($urandom) :
						16'($urandom_range(50, 1100));
					frame_v = ($urandom_range(3) == 0) ? 16'($urandom) :
						16'($urandom_range(5000, 45000));
				end
			endcase
			drain();
			write_settings(count_v, pulse_v, frame_v, seg[0]);

			for (int i = 0; i < SEG_ITEMS; i++) begin
				case ($urandom_range(9))
					0, 1: width_v = 16'($urandom);
					2:    width_v = 16'($urandom_range(0, 1000));
					default: width_v = 16'($urandom_range(700, 2300));
				endcase
				send_width(width_v);
				// now and then change the count with a frame half done
				if ($urandom_range(49) == 0) begin
					drain();
					write_reg(CFG_CHANNEL_COUNT, 16'($urandom_range(0, 16)));
					cfg_valid <= 1'b0;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
